/* rtl/lph_pkg.sv */
package lph_pkg;

    localparam int BucketAw  = 10;
    localparam int Buckets   = 1 << BucketAw;
    localparam int EntryAw   = 10;
    localparam int Entries   = 1 << EntryAw;
    localparam int CntW      = BucketAw + 1;
    localparam int LiveW     = 11;
    localparam int KeyW      = 64;
    localparam int Log2W     = 4;

    localparam logic [63:0] HashMul = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
    localparam logic [63:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ExpOnes = 64'h7FF0_0000_0000_0000;

    localparam logic [Log2W-1:0] Log2Min = 4'd1;
    localparam logic [Log2W-1:0] Log2Max = 4'(BucketAw);

    localparam logic [2:0] PaddrLog2   = 3'h0;
    localparam logic [2:0] PaddrFormat = 3'h4;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_USED  = 2'd2
    } t_tag;

    typedef enum logic [2:0] {
        K_FIND   = 3'd0,
        K_INSERT = 3'd1,
        K_REMOVE = 3'd2,
        K_UPDATE = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef struct packed {
        t_tag                tag;
        logic [EntryAw-1:0]  val;
    } t_bucket;

    typedef struct packed {
        logic [BucketAw-1:0] mask;
        logic [BucketAw-1:0] hash;
    } t_probe;

    // Integer keys compare bit for bit; double keys use IEEE equality.
    function automatic logic keys_equal(logic [63:0] a, logic [63:0] b, logic fmt);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a & AbsMask) > ExpOnes;
        b_nan = (b & AbsMask) > ExpOnes;
        zeros = ((a & AbsMask) == 64'd0) && ((b & AbsMask) == 64'd0);
        if (!fmt) begin
            return a == b;
        end
        if (a_nan || b_nan) begin
            return 1'b0;
        end
        return zeros || (a == b);
    endfunction

endpackage

/* rtl/lph_if.sv */
interface lph_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic signed [63:0] key;
    logic [9:0]  dense_index;
    logic [9:0]  new_index;
    logic [10:0] live_count;
    modport source (output valid, kind, key, dense_index, new_index, live_count,
                    input ready);
    modport sink   (input valid, kind, key, dense_index, new_index, live_count,
                    output ready);
endinterface

interface lph_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [9:0] index;
    logic       status;
    modport source (output valid, found, index, status, input ready);
    modport sink   (input valid, found, index, status, output ready);
endinterface

/* rtl/lph_ram.sv */
module lph_ram #(
    parameter int Depth = 1024,
    parameter int Width = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lph_hash.sv */
module lph_hash (
    input  logic [63:0]               i_key,
    input  logic                      i_format,
    input  logic [lph_pkg::Log2W-1:0] i_log2,
    output lph_pkg::t_probe           o_probe
);
    import lph_pkg::*;

    logic [63:0]          bits;
    logic [2*BucketAw-1:0] prod;
    logic [Log2W-1:0]     n;
    logic [CntW-1:0]      count;

    always_comb begin
        // Folding negative zero keeps both zeros in one probe chain.
        bits = (i_format && i_key == NegZero) ? 64'd0 : i_key;
        // Only the low bits of the product reach the bucket address.
        prod = bits[BucketAw-1:0] * HashMul[BucketAw-1:0];
        if (i_log2 < Log2Min) begin
            n = Log2Min;
        end else if (i_log2 > Log2Max) begin
            n = Log2Max;
        end else begin
            n = i_log2;
        end
        count = CntW'(1) << n;
        o_probe.hash = prod[BucketAw-1:0];
        o_probe.mask = BucketAw'(count - CntW'(1));
    end
endmodule

/* rtl/linear_probe_hash_index.sv */
// Channel   Dir  Transfer when        Payload
// i_in      in   valid && ready       kind, key, dense_index, new_index, live_count
// o_out     out  valid && ready       found, index, status
// apb       in   psel&penable&pwrite  bucket_count_log2 at 0x0, key_format at 0x4
//
// Each probe is a bucket memory read (S_RD) followed by an evaluation (S_EVAL).
// A find whose bucket names a live entry adds a key memory read and compare (S_KCMP).
// After reset a clearing pass empties every bucket of the bucket memory, and clear
// runs the same pass; i_in is not ready meanwhile. A result waits in the output
// register while o_out stalls.
module linear_probe_hash_index (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lph_in_if.sink         i_in,
    lph_out_if.source      o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import lph_pkg::*;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_EVAL = 6'b001000,
        S_KCMP = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [Log2W-1:0] r_log2;
    logic             r_format;

    // Operation context, captured at the input transfer.
    logic [2:0]          r_kind;
    logic [63:0]         r_key;
    logic [EntryAw-1:0]  r_dense, r_new, r_val, n_val;
    logic [LiveW-1:0]    r_live;
    logic [BucketAw-1:0] r_mask, n_mask, r_addr, n_addr, r_clr, n_clr;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic                r_clr_op, n_clr_op;
    logic                r_found, n_found, r_status, n_status;
    logic [EntryAw-1:0]  r_index, n_index;

    // Output register.
    logic                r_ovalid, r_ofound, r_ostatus;
    logic [EntryAw-1:0]  r_oindex;

    t_probe              probe;
    t_bucket             b_rd, b_wd;
    logic                b_we, b_re;
    logic [BucketAw-1:0] b_waddr;
    logic [63:0]         k_rd;
    logic                k_we, k_re;
    logic                accept, last, out_free;

    lph_hash u_hash (
        .i_key    (i_in.key),
        .i_format (r_format),
        .i_log2   (r_log2),
        .o_probe  (probe)
    );

    lph_ram #(.Depth(Buckets), .Width($bits(t_bucket))) u_bucket (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wd),
        .i_re    (b_re),
        .i_raddr (r_addr),
        .o_rdata (b_rd)
    );

    lph_ram #(.Depth(Entries), .Width(KeyW)) u_key (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_dense),
        .i_wdata (r_key),
        .i_re    (k_re),
        .i_raddr (b_rd.val),
        .o_rdata (k_rd)
    );

    assign pready      = 1'b1;
    assign prdata      = (paddr == PaddrFormat) ? {31'd0, r_format} : {28'd0, r_log2};
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_ovalid || o_out.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.found  = r_ofound;
    assign o_out.index  = r_oindex;
    assign o_out.status = r_ostatus;
    // The probe ends once every bucket in use has been visited.
    assign last = (r_cnt + CntW'(1)) == ({1'b0, r_mask} + CntW'(1));

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_mask   = r_mask;
        n_val    = r_val;
        n_clr    = r_clr;
        n_clr_op = r_clr_op;
        n_found  = r_found;
        n_index  = r_index;
        n_status = r_status;
        b_we     = 1'b0;
        b_re     = 1'b0;
        b_waddr  = r_addr;
        b_wd     = b_rd;
        k_we     = 1'b0;
        k_re     = 1'b0;

        unique case (r_state)
            S_CLR: begin
                b_we    = 1'b1;
                b_waddr = r_clr;
                b_wd    = '{tag: TAG_EMPTY, val: '0};
                n_clr   = r_clr + BucketAw'(1);
                if (r_clr == BucketAw'(Buckets - 1)) begin
                    n_state = r_clr_op ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    // The first bucket lies inside the buckets in use.
                    n_addr   = probe.hash & probe.mask;
                    n_mask   = probe.mask;
                    n_cnt    = '0;
                    n_found  = 1'b0;
                    n_index  = '0;
                    n_status = (i_in.kind == K_INSERT);
                    if (i_in.kind == K_CLEAR) begin
                        n_clr    = '0;
                        n_clr_op = 1'b1;
                        n_state  = S_CLR;
                    end else if (i_in.kind == K_FIND || i_in.kind == K_INSERT ||
                                 i_in.kind == K_REMOVE || i_in.kind == K_UPDATE) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                b_re    = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_val = b_rd.val;
                // Default: step to the next bucket or give up.
                n_addr  = (r_addr + BucketAw'(1)) & r_mask;
                n_cnt   = r_cnt + CntW'(1);
                n_state = last ? S_FIN : S_RD;
                if (r_kind == K_FIND) begin
                    if (b_rd.tag == TAG_EMPTY) begin
                        n_state = S_FIN;
                    end else if (b_rd.tag == TAG_USED &&
                                 {1'b0, b_rd.val} < r_live) begin
                        k_re    = 1'b1;
                        n_state = S_KCMP;
                    end
                end else if (r_kind == K_INSERT) begin
                    if (b_rd.tag != TAG_USED) begin
                        b_we     = 1'b1;
                        b_wd     = '{tag: TAG_USED, val: r_dense};
                        k_we     = 1'b1;
                        n_status = 1'b0;
                        n_state  = S_FIN;
                    end
                end else begin
                    if (b_rd.tag == TAG_USED && b_rd.val == r_dense) begin
                        b_we = 1'b1;
                        if (r_kind == K_REMOVE) begin
                            b_wd = '{tag: TAG_TOMB, val: '0};
                        end else begin
                            b_wd = '{tag: TAG_USED, val: r_new};
                        end
                        n_found = 1'b1;
                        n_state = S_FIN;
                    end else if (b_rd.tag == TAG_EMPTY) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_KCMP: begin
                if (keys_equal(k_rd, r_key, r_format)) begin
                    n_found = 1'b1;
                    n_index = r_val;
                    n_state = S_FIN;
                end else begin
                    // The address and count already point at the next probe.
                    n_state = (r_cnt == ({1'b0, r_mask} + CntW'(1))) ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_clr_op <= 1'b0;
            r_ovalid <= 1'b0;
            r_log2   <= 4'(BucketAw);
            r_format <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_clr_op <= (r_state == S_FIN) ? 1'b0 : n_clr_op;
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == PaddrFormat[2]) begin
                    r_format <= pwdata[0];
                end else begin
                    r_log2 <= pwdata[Log2W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_mask   <= n_mask;
        r_val    <= n_val;
        r_found  <= n_found;
        r_index  <= n_index;
        r_status <= n_status;
        if (accept) begin
            r_kind  <= i_in.kind;
            r_key   <= i_in.key;
            r_dense <= i_in.dense_index;
            r_new   <= i_in.new_index;
            r_live  <= i_in.live_count;
        end
        if (r_state == S_FIN && out_free) begin
            r_ofound  <= r_found;
            r_oindex  <= r_index;
            r_ostatus <= r_status;
        end
    end

`ifndef SYNTHESIS
    // A new operation is never taken in the cycle right after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input taken while an operation is in flight");

    // An insert that ran out of buckets never reports a hit.
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.status && o_out.found))
        else $error("status and found both set");

    // Only a find hit carries a nonzero index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.index == '0))
        else $error("index set without a hit");

    // The probe count never passes the number of buckets in use.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_cnt <= {1'b0, r_mask}))
        else $error("probe ran past the bucket count");
`endif
endmodule
